### design/scnc_pkg.sv
// Package for the cell reference converter: widths, character codes,
// shared structs and the saturating accumulate helper.
// No dependencies.
package scnc_pkg;

  localparam int VALUE_BITS = 24;
  localparam longint unsigned DEC_CAP = 64'd99999999;
  localparam longint unsigned FULL_MAX = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [VALUE_BITS-1:0] VAL_LIMIT =
      VALUE_BITS'((FULL_MAX < DEC_CAP) ? FULL_MAX : DEC_CAP);

  // 26 * value + 58 always fits in six extra bits.
  localparam int ACC_W = VALUE_BITS + 6;

  // Decimal output has at most eight digits and letter output at most six.
  localparam int DIG_DEPTH = 8;
  localparam int DIG_IDX_W = $clog2(DIG_DEPTH);
  localparam int SP_W      = $clog2(DIG_DEPTH + 1);

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_AT   = 8'd64;
  localparam logic [7:0] CH_R    = 8'd82;
  localparam logic [7:0] CH_C    = 8'd67;

  localparam logic [5:0] DIV_DEC   = 6'd10;
  localparam logic [5:0] DIV_ALPHA = 6'd26;

  // Scaled reciprocals, rounded up. With five guard bits beyond VALUE_BITS the
  // rounding error never reaches the quotient for any dividend below 2^VALUE_BITS.
  localparam int RECIP_SHIFT = VALUE_BITS + 5;
  localparam int RECIP_W     = VALUE_BITS + 2;
  localparam int PROD_W      = VALUE_BITS + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_DEC =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_DEC) - 64'd1) / 64'(DIV_DEC));
  localparam logic [RECIP_W-1:0] RECIP_ALPHA =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_ALPHA) - 64'd1) / 64'(DIV_ALPHA));

  typedef struct packed {
    logic                  rc_form;
    logic [VALUE_BITS-1:0] rc_row;
    logic [VALUE_BITS-1:0] rc_col;
    logic [VALUE_BITS-1:0] a1_row;
    logic [VALUE_BITS-1:0] a1_col;
  } scnc_vals_t;

  typedef struct packed {
    logic start;
    logic alpha;
  } scnc_div_ctl_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [4:0]            remainder;
  } scnc_div_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
  endfunction

  // v * 10 + add or v * 26 + add, clamped at VAL_LIMIT.
  function automatic logic [VALUE_BITS-1:0] sat_acc(input logic [VALUE_BITS-1:0] v,
                                                    input logic alpha,
                                                    input logic [5:0] add);
    logic [ACC_W-1:0] w;
    logic [ACC_W-1:0] r;
    w = ACC_W'(v);
    if (alpha) begin
      r = (w << 4) + (w << 3) + (w << 1);
    end else begin
      r = (w << 3) + (w << 1);
    end
    r = r + ACC_W'(add);
    sat_acc = (r > ACC_W'(VAL_LIMIT)) ? VAL_LIMIT : r[VALUE_BITS-1:0];
  endfunction

endpackage

### design/scnc_in_if.sv
// Input channel of the cell reference converter: one token character per
// transaction. No dependencies.
interface scnc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink (input valid, input char_in, input is_last, output ready);
endinterface

### design/scnc_out_if.sv
// Output channel of the cell reference converter: one converted character
// per transaction. No dependencies.
interface scnc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last_out;

  modport source (output valid, output char_out, output last_out, input ready);
  modport sink (input valid, input char_out, input last_out, output ready);
endinterface

### design/spreadsheet_cell_notation_converter_top.sv
// Top level of the cell reference converter: output sequencer, digit stack
// and output register around the parser and the shared divider.
// Depends on scnc_pkg, scnc_in_if, scnc_out_if, scnc_parser, scnc_divider.
//
//   channel  side  payload             transaction
//   token    sink  char_in, is_last    one character of the reference token
//   result   src   char_out, last_out  one character of the converted reference
//
// A character that is not the last is taken while the sequencer waits in ST_PARSE,
// so such characters can follow back to back. The last one starts the conversion,
// during which token.ready is low: each segment is set up in ST_SEG (a literal is
// then sent from ST_LIT), each decimal digit or column letter passes through
// ST_START and the shared divider, and each stacked character leaves through the
// output register. Reset is synchronous; a stalled result holds the sequencer in place.
module spreadsheet_cell_notation_converter_top (
  input logic clk,
  input logic rst,
  scnc_in_if.sink    token,
  scnc_out_if.source result
);
  import scnc_pkg::*;

  localparam logic [2:0] ST_PARSE = 3'd0;
  localparam logic [2:0] ST_SEG   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_LIT   = 3'd5;

  localparam logic [1:0] SEG_0 = 2'd0;
  localparam logic [1:0] SEG_1 = 2'd1;
  localparam logic [1:0] SEG_2 = 2'd2;
  localparam logic [1:0] SEG_3 = 2'd3;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [1:0]            seg;
  logic [VALUE_BITS-1:0] work;
  logic [4:0]            digits [DIG_DEPTH];
  logic [SP_W-1:0]       sp;
  logic                  out_valid;
  logic [7:0]            out_char;
  logic                  out_last;

  scnc_vals_t            vals;
  scnc_div_ctl_t         div_ctl;
  scnc_div_res_t         div_res;

  logic                  take;
  logic                  out_free;
  logic                  seg_lit;
  logic                  seg_alpha;
  logic                  seg_last;
  logic [VALUE_BITS-1:0] seg_value;
  logic [7:0]            lit_char;
  logic [SP_W-1:0]       sp_dec;
  logic [4:0]            top_digit;
  logic                  emit_dig;
  logic                  emit_lit;
  logic                  advance;
  logic                  finish;

  assign take     = token.valid && token.ready;
  assign out_free = !out_valid || result.ready;

  assign seg_lit   = !vals.rc_form && (seg == SEG_0 || seg == SEG_2);
  assign seg_alpha = vals.rc_form && (seg == SEG_0);
  assign seg_last  = vals.rc_form ? (seg == SEG_1) : (seg == SEG_3);
  assign lit_char  = (seg == SEG_0) ? CH_R : CH_C;

  always_comb begin
    case (seg)
      SEG_0:   seg_value = vals.rc_form ? vals.rc_col : vals.a1_row;
      SEG_1:   seg_value = vals.rc_form ? vals.rc_row : vals.a1_row;
      default: seg_value = vals.a1_col;
    endcase
  end

  assign sp_dec    = sp - SP_W'(1);
  assign top_digit = digits[sp_dec[DIG_IDX_W-1:0]];

  assign emit_dig = (state == ST_EMIT) && out_free;
  assign emit_lit = (state == ST_LIT) && out_free;
  // A segment ends after a literal, after its last stacked digit, or when a
  // zero column in R-C form gives no letters at all.
  assign advance  = emit_lit || (emit_dig && sp == SP_W'(1)) ||
                    ((state == ST_SEG) && seg_alpha && seg_value == '0);
  assign finish   = advance && seg_last;

  assign div_ctl.start = (state == ST_START);
  assign div_ctl.alpha = seg_alpha;

  scnc_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .char_in (token.char_in),
    .clear   (finish),
    .vals    (vals)
  );

  scnc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (work),
    .res      (div_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_PARSE: begin
        if (take && token.is_last) state_next = ST_SEG;
      end
      ST_SEG: begin
        if (seg_lit) state_next = ST_LIT;
        else if (!(seg_alpha && seg_value == '0)) state_next = ST_START;
      end
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_res.done) begin
          state_next = (div_res.quotient != '0) ? ST_START : ST_EMIT;
        end
      end
      ST_EMIT, ST_LIT: begin
        if (advance) state_next = seg_last ? ST_PARSE : ST_SEG;
      end
      default: state_next = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_PARSE;
      seg       <= SEG_0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) seg <= seg_last ? SEG_0 : seg + 2'd1;
      if (state == ST_DIV && div_res.done) sp <= sp + SP_W'(1);
      else if (emit_dig) sp <= sp_dec;
      if (emit_dig || emit_lit) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEG) begin
      work <= seg_alpha ? seg_value - VALUE_BITS'(1) : seg_value;
    end else if (state == ST_DIV && div_res.done) begin
      work <= seg_alpha ? div_res.quotient - VALUE_BITS'(1) : div_res.quotient;
      // Letters are kept as 1..26 so that they print as CH_AT + digit.
      digits[sp[DIG_IDX_W-1:0]] <= seg_alpha ? div_res.remainder + 5'd1
                                             : div_res.remainder;
    end
    if (emit_lit) begin
      out_char <= lit_char;
      out_last <= 1'b0;
    end else if (emit_dig) begin
      out_char <= (seg_alpha ? CH_AT : CH_ZERO) + {3'b000, top_digit};
      out_last <= seg_last && sp == SP_W'(1);
    end
  end

  assign token.ready     = (state == ST_PARSE);
  assign result.valid    = out_valid;
  assign result.char_out = out_char;
  assign result.last_out = out_last;

endmodule

### design/scnc_parser.sv
// Token parser: reads one character per cycle while take is high and keeps both the R-C and the
// letters-digits reading of the token. Depends on scnc_pkg.
module scnc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         char_in,
  input  logic               clear,
  output scnc_pkg::scnc_vals_t vals
);
  import scnc_pkg::*;

  localparam logic [1:0] RC_FIRST = 2'd0;
  localparam logic [1:0] RC_ROW   = 2'd1;
  localparam logic [1:0] RC_COL   = 2'd2;
  localparam logic [1:0] RC_DONE  = 2'd3;

  localparam logic [1:0] A1_LETTERS = 2'd0;
  localparam logic [1:0] A1_DIGITS  = 2'd1;
  localparam logic [1:0] A1_DONE    = 2'd2;

  logic [4:0]            position;
  logic                  starts_with_r;
  logic                  second_is_digit;
  logic                  saw_c_letter;
  logic [VALUE_BITS-1:0] rc_row_value;
  logic [VALUE_BITS-1:0] rc_col_value;
  logic [1:0]            rc_phase;
  logic [VALUE_BITS-1:0] a1_col_value;
  logic [VALUE_BITS-1:0] a1_row_value;
  logic [1:0]            a1_phase;

  logic [VALUE_BITS-1:0] rc_row_next;
  logic [VALUE_BITS-1:0] rc_col_next;
  logic [1:0]            rc_phase_next;
  logic [VALUE_BITS-1:0] a1_col_next;
  logic [VALUE_BITS-1:0] a1_row_next;
  logic [1:0]            a1_phase_next;
  logic                  dig;
  logic                  alp;
  logic [5:0]            dig_val;
  logic [5:0]            alp_val;

  assign dig     = is_digit(char_in);
  assign alp     = is_alpha(char_in);
  assign dig_val = 6'(char_in - CH_ZERO);
  assign alp_val = 6'(char_in - CH_AT);

  always_comb begin
    rc_row_next   = rc_row_value;
    rc_col_next   = rc_col_value;
    rc_phase_next = rc_phase;
    case (rc_phase)
      RC_FIRST: rc_phase_next = RC_ROW;
      RC_ROW: begin
        if (dig) rc_row_next = sat_acc(rc_row_value, 1'b0, dig_val);
        else rc_phase_next = RC_COL;
      end
      RC_COL: begin
        if (dig) rc_col_next = sat_acc(rc_col_value, 1'b0, dig_val);
        else rc_phase_next = RC_DONE;
      end
      default: rc_phase_next = rc_phase;
    endcase
  end

  always_comb begin
    a1_col_next   = a1_col_value;
    a1_row_next   = a1_row_value;
    a1_phase_next = a1_phase;
    case (a1_phase)
      A1_LETTERS: begin
        if (alp) begin
          a1_col_next = sat_acc(a1_col_value, 1'b1, alp_val);
        end else if (dig) begin
          a1_phase_next = A1_DIGITS;
          a1_row_next   = sat_acc(a1_row_value, 1'b0, dig_val);
        end else begin
          a1_phase_next = A1_DONE;
        end
      end
      A1_DIGITS: begin
        if (dig) a1_row_next = sat_acc(a1_row_value, 1'b0, dig_val);
        else a1_phase_next = A1_DONE;
      end
      default: a1_phase_next = a1_phase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      position        <= '0;
      starts_with_r   <= 1'b0;
      second_is_digit <= 1'b0;
      saw_c_letter    <= 1'b0;
      rc_row_value    <= '0;
      rc_col_value    <= '0;
      rc_phase        <= RC_FIRST;
      a1_col_value    <= '0;
      a1_row_value    <= '0;
      a1_phase        <= A1_LETTERS;
    end else if (take) begin
      if (position == 5'd0 && char_in == CH_R) starts_with_r <= 1'b1;
      if (position == 5'd1 && dig) second_is_digit <= 1'b1;
      if (char_in == CH_C) saw_c_letter <= 1'b1;
      if (position != 5'd31) position <= position + 5'd1;
      rc_row_value <= rc_row_next;
      rc_col_value <= rc_col_next;
      rc_phase     <= rc_phase_next;
      a1_col_value <= a1_col_next;
      a1_row_value <= a1_row_next;
      a1_phase     <= a1_phase_next;
    end
  end

  assign vals.rc_form = starts_with_r && second_is_digit && saw_c_letter;
  assign vals.rc_row  = rc_row_value;
  assign vals.rc_col  = rc_col_value;
  assign vals.a1_row  = a1_row_value;
  assign vals.a1_col  = a1_col_value;

endmodule

### design/scnc_divider.sv
// Shared divider by 10 or 26: multiplies by a scaled reciprocal, then gets the
// remainder back with shifts. done is registered after the DV_MUL, DV_QUO and DV_REM steps. Depends on scnc_pkg.
module scnc_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  scnc_pkg::scnc_div_ctl_t ctl,
  input  logic [scnc_pkg::VALUE_BITS-1:0] dividend,
  output scnc_pkg::scnc_div_res_t res
);
  import scnc_pkg::*;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_MUL  = 2'd1;
  localparam logic [1:0] DV_QUO  = 2'd2;
  localparam logic [1:0] DV_REM  = 2'd3;

  logic [1:0]            step;
  logic                  done;
  logic                  alpha;
  logic [VALUE_BITS-1:0] num;
  logic [RECIP_W-1:0]    recip;
  logic [PROD_W-1:0]     product;
  logic [VALUE_BITS-1:0] quotient;
  logic [4:0]            remainder;

  logic [VALUE_BITS-1:0] back;
  logic [4:0]            rest;

  // The quotient times the divisor never exceeds the dividend.
  assign back = alpha ? (quotient << 4) + (quotient << 3) + (quotient << 1)
                      : (quotient << 3) + (quotient << 1);
  assign rest = 5'(num - back);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= DV_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (step)
        DV_IDLE: begin
          if (ctl.start) step <= DV_MUL;
        end
        DV_MUL: step <= DV_QUO;
        DV_QUO: step <= DV_REM;
        DV_REM: begin
          step <= DV_IDLE;
          done <= 1'b1;
        end
        default: step <= DV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step == DV_IDLE && ctl.start) begin
      num   <= dividend;
      alpha <= ctl.alpha;
      recip <= ctl.alpha ? RECIP_ALPHA : RECIP_DEC;
    end
    if (step == DV_MUL) product <= PROD_W'(num) * PROD_W'(recip);
    if (step == DV_QUO) quotient <= VALUE_BITS'(product >> RECIP_SHIFT);
    if (step == DV_REM) remainder <= rest;
  end

  assign res.done      = done;
  assign res.quotient  = quotient;
  assign res.remainder = remainder;

endmodule

### bench/tb_spreadsheet_cell_notation_converter_top.sv
// Testbench for the cell reference converter: drives reference tokens one
// character at a time and checks every converted character against a predictor.
// Depends on scnc_pkg, scnc_in_if, scnc_out_if and the converter top level.
module tb_spreadsheet_cell_notation_converter_top;
  import scnc_pkg::*;

  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_LOW_A = 8'd97;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UP_Z  = 8'd90;
  localparam logic [7:0] CH_LOW_Z = 8'd122;
  localparam int unsigned RADIX_DEC   = 10;
  localparam int unsigned RADIX_ALPHA = 26;
  localparam int TARGET_ITEMS = 230;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = 200;

  typedef enum logic [1:0] {RC_LEAD, RC_ROW, RC_COL, RC_DONE} rc_step_t;
  typedef enum logic [1:0] {A1_LETTERS, A1_DIGITS, A1_DONE} a1_step_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    logic       drain;
  } token_char_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } out_char_t;

  logic clk;
  logic rst;

  scnc_in_if  token_ch ();
  scnc_out_if result_ch ();

  spreadsheet_cell_notation_converter_top i_dut (
    .clk(clk),
    .rst(rst),
    .token(token_ch),
    .result(result_ch)
  );

  token_char_t feed_q[$];
  out_char_t   expected_chars[$];
  logic [7:0]  tok_chars[$];
  logic [7:0]  out_text[$];

  // Predictor state for the token being parsed.
  logic [4:0]            tok_pos = '0;
  logic                  tok_r_first = 1'b0;
  logic                  tok_digit_second = 1'b0;
  logic                  tok_has_c = 1'b0;
  rc_step_t              rc_step = RC_LEAD;
  logic [VALUE_BITS-1:0] rc_row = '0;
  logic [VALUE_BITS-1:0] rc_col = '0;
  a1_step_t              a1_step = A1_LETTERS;
  logic [VALUE_BITS-1:0] a1_row = '0;
  logic [VALUE_BITS-1:0] a1_col = '0;

  int        errors = 0;
  int        accepted_chars = 0;
  int        results_seen = 0;
  int        gap_left = 0;
  int        burst_left = 1;
  logic      drain_armed = 1'b0;
  logic      can_offer;
  out_char_t want;

  int       rx_cycle;
  int       hold_left;
  logic     hold_done;
  logic [7:0] rx_pattern;
  logic     rdy;

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_A && c <= CH_UP_Z) || (c >= CH_LOW_A && c <= CH_LOW_Z);
  endfunction

  function automatic logic [VALUE_BITS-1:0] grow(input logic [VALUE_BITS-1:0] v,
                                                 input int unsigned radix,
                                                 input logic [7:0] add);
    longint unsigned wide;
    wide = 64'(v) * radix + 64'(add);
    return (wide > 64'(VAL_LIMIT)) ? VAL_LIMIT : VALUE_BITS'(wide);
  endfunction

  task automatic add_decimal(input logic [VALUE_BITS-1:0] v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) out_text.push_back(s[i]);
  endtask

  // Parses one character both ways; on the final one it queues the converted text.
  task automatic convert_token_char(input logic [7:0] c, input logic fin);
    logic [VALUE_BITS-1:0] v;
    if (tok_pos == 5'd0 && c == CH_R) tok_r_first = 1'b1;
    if (tok_pos == 5'd1 && is_numeral(c)) tok_digit_second = 1'b1;
    if (c == CH_C) tok_has_c = 1'b1;

    case (rc_step)
      RC_LEAD: rc_step = RC_ROW;
      RC_ROW: begin
        if (is_numeral(c)) rc_row = grow(rc_row, RADIX_DEC, c - CH_ZERO);
        else rc_step = RC_COL;
      end
      RC_COL: begin
        if (is_numeral(c)) rc_col = grow(rc_col, RADIX_DEC, c - CH_ZERO);
        else rc_step = RC_DONE;
      end
      default: ;
    endcase

    case (a1_step)
      A1_LETTERS: begin
        if (is_letter(c)) begin
          a1_col = grow(a1_col, RADIX_ALPHA, c - CH_AT);
        end else if (is_numeral(c)) begin
          a1_step = A1_DIGITS;
          a1_row = grow(a1_row, RADIX_DEC, c - CH_ZERO);
        end else begin
          a1_step = A1_DONE;
        end
      end
      A1_DIGITS: begin
        if (is_numeral(c)) a1_row = grow(a1_row, RADIX_DEC, c - CH_ZERO);
        else a1_step = A1_DONE;
      end
      default: ;
    endcase

    if (tok_pos != 5'd31) tok_pos = tok_pos + 5'd1;

    if (fin) begin
      out_text.delete();
      if (tok_r_first && tok_digit_second && tok_has_c) begin
        // Bijective base 26: letters come out least significant first.
        v = rc_col;
        while (v != '0) begin
          v = v - VALUE_BITS'(1);
          out_text.push_front(CH_A + 8'(v % RADIX_ALPHA));
          v = VALUE_BITS'(v / RADIX_ALPHA);
        end
        add_decimal(rc_row);
      end else begin
        out_text.push_back(CH_R);
        add_decimal(a1_row);
        out_text.push_back(CH_C);
        add_decimal(a1_col);
      end
      foreach (out_text[i]) expected_chars.push_back('{out_text[i], i == out_text.size() - 1});
      tok_pos = '0;
      tok_r_first = 1'b0;
      tok_digit_second = 1'b0;
      tok_has_c = 1'b0;
      rc_step = RC_LEAD;
      rc_row = '0;
      rc_col = '0;
      a1_step = A1_LETTERS;
      a1_row = '0;
      a1_col = '0;
    end
  endtask

  task automatic queue_token(input logic drain);
    foreach (tok_chars[i]) begin
      feed_q.push_back('{tok_chars[i], i == tok_chars.size() - 1, drain && i == 0});
    end
    tok_chars.delete();
  endtask

  task automatic add_token(input string s);
    for (int i = 0; i < s.len(); i++) tok_chars.push_back(s[i]);
    queue_token(1'b0);
  endtask

  // Mostly short numbers, now and then long enough to saturate.
  function automatic int digit_count(input int lo);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11) : $urandom_range(lo, 3);
  endfunction

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) tok_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_letters(input int n);
    for (int i = 0; i < n; i++) begin
      tok_chars.push_back(($urandom_range(0, 1) ? CH_A : CH_LOW_A) + 8'($urandom_range(0, 25)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // Token driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      token_ch.valid <= 1'b0;
      token_ch.char_in <= '0;
      token_ch.is_last <= 1'b0;
    end else if (!token_ch.valid || token_ch.ready) begin
      if (token_ch.valid) begin
        void'(feed_q.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      can_offer = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (feed_q.size() != 0) begin
        // A draining token waits until every converted character has come back.
        if (!feed_q[0].drain) begin
          can_offer = 1'b1;
        end else if (drain_armed && expected_chars.size() == 0) begin
          can_offer = 1'b1;
          drain_armed = 1'b0;
        end else begin
          drain_armed = 1'b1;
        end
      end
      token_ch.valid <= can_offer;
      if (can_offer) begin
        token_ch.char_in <= feed_q[0].ch;
        token_ch.is_last <= feed_q[0].fin;
      end
    end
  end

  // Result receiver: stall pattern is picked from the upper bits of rx_cycle, plus one long hold.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_cycle <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      rx_pattern <= 8'h5A;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle[6:0] == 7'd0) rx_pattern <= 8'($urandom);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: rdy = 1'b1;
          2'd1: rdy = 1'($urandom_range(0, 1));
          2'd2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = rx_pattern[rx_cycle[2:0]];
        endcase
      end
      result_ch.ready <= rdy;
    end
  end

  // Monitor: predict from accepted characters first, then check results.
  always @(posedge clk) begin
    if (!rst) begin
      if (token_ch.valid && token_ch.ready) begin
        convert_token_char(token_ch.char_in, token_ch.is_last);
        accepted_chars++;
      end
      if (result_ch.valid && result_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_chars.size() == 0) begin
          $error("unexpected result: char_out %0d last_out %0d",
                 result_ch.char_out, result_ch.last_out);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (result_ch.char_out !== want.ch) begin
            $error("char_out mismatch: expected %0d, actual %0d", want.ch, result_ch.char_out);
            errors++;
          end
          if (result_ch.last_out !== want.fin) begin
            $error("last_out mismatch: expected %0d, actual %0d", want.fin, result_ch.last_out);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int   roll;
    int   n;
    logic first;
    logic [7:0] pick;

    rst = 1'b1;

    add_token("R1C1");
    add_token("R0C0");
    add_token("b7");
    add_token("RC");
    add_token("R5");
    add_token("Z");
    add_token("R2X3C");
    tok_chars.push_back(8'hFF);
    queue_token(1'b0);
    tok_chars.push_back(8'h00);
    queue_token(1'b0);

    first = 1'b1;
    while (feed_q.size() < TARGET_ITEMS) begin
      roll = $urandom_range(0, 15);
      if (first) begin
        // Longer than the position counter and with a saturating column.
        tok_chars.push_back(CH_R);
        push_digits(1);
        tok_chars.push_back(CH_C);
        push_digits(33);
      end else if (roll <= 5) begin
        tok_chars.push_back(CH_R);
        push_digits(digit_count(1));
        tok_chars.push_back(CH_C);
        push_digits(digit_count(0));
      end else if (roll <= 10) begin
        push_letters(($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3));
        push_digits(digit_count(0));
      end else if (roll <= 12) begin
        // R-C shape with an arbitrary separator and junk around it.
        tok_chars.push_back($urandom_range(0, 1) ? CH_R : 8'($urandom_range(0, 255)));
        push_digits($urandom_range(0, 3));
        tok_chars.push_back($urandom_range(0, 2) == 0 ? CH_C : 8'($urandom_range(0, 255)));
        push_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1)) tok_chars.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: pick = CH_R;
            1: pick = CH_C;
            2: pick = CH_ZERO + 8'($urandom_range(0, 9));
            default: pick = 8'($urandom_range(0, 255));
          endcase
          tok_chars.push_back(pick);
        end
      end
      queue_token(first || $urandom_range(0, 15) == 0);
      first = 1'b0;
    end

    n = feed_q.size();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (accepted_chars < n || expected_chars.size() != 0);
    repeat (QUIET_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
